>>> hw/rtl/pta_pkg.sv
`default_nettype none

package pta_pkg;

   localparam int MAX_ALIASES   = 10;
   localparam int MAX_ALIAS_LEN = 50;

   localparam int CW = $clog2(MAX_ALIASES + 1);
   localparam int IW = (MAX_ALIASES > 1) ? $clog2(MAX_ALIASES) : 1;
   localparam int LW = $clog2(MAX_ALIAS_LEN + 1);
   localparam int TW = $clog2(MAX_ALIAS_LEN + 2);
   localparam int AW = (MAX_ALIAS_LEN > 1) ? $clog2(MAX_ALIAS_LEN) : 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QW = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   typedef enum logic [1:0] {
      KIND_ALIAS_CHAR,
      KIND_ALIAS_COMMA,
      KIND_PATH_CHAR,
      KIND_PATH_SEP
   } kind_type;

   typedef struct packed {
      logic       action;
      logic [7:0] byte_value;
      logic       last;
   } req_type;

   typedef struct packed {
      logic done_res;
      logic found;
   } rsp_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_value;
      logic       last;
   } item_type;

   typedef logic [MAX_ALIASES-1:0] mask_type;
   typedef logic [MAX_ALIASES-1:0][LW-1:0] lens_type;

   typedef struct packed {
      logic       is_path;
      logic       is_sep;
      logic       last;
      logic [7:0] byte_value;
      mask_type   keep_mask;
      mask_type   close_mask;
      mask_type   final_mask;
   } exec_type;

   function automatic logic is_separator(logic [7:0] c);
      return c inside {8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28,
                       8'h29, 8'h2D, 8'h2B, 8'h2F, 8'h3C, 8'h3E, 8'h2C, 8'h7C};
   endfunction

   // Aliases whose length equals a closed token of nonzero, matchable length.
   function automatic mask_type close_hits(logic [TW-1:0] tl, logic [CW-1:0] cnt,
                                           lens_type lens);
      mask_type m;
      m = '0;
      for (int i = 0; i < MAX_ALIASES; i++) begin
         m[i] = (tl != '0) && (tl <= TW'(MAX_ALIAS_LEN)) && (CW'(i) < cnt)
                && (TW'(lens[i]) == tl);
      end
      return m;
   endfunction

   // Aliases that can still extend a match at token position tl.
   function automatic mask_type keep_allowed(logic [TW-1:0] tl, logic [CW-1:0] cnt,
                                             lens_type lens);
      mask_type m;
      m = '0;
      for (int i = 0; i < MAX_ALIASES; i++) begin
         m[i] = (CW'(i) < cnt) && (tl < TW'(lens[i]));
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/path_token_alias_matcher.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   pta_pkg::req_type (action, byte_value, last)
// rsp       out        rsp_valid/rsp_stall   pta_pkg::rsp_type (done_res, found)
//
// One transaction is accepted per cycle while req_stall is low, and each gives
// exactly one response. Before rsp_valid rises, a transaction passes through
// the queue, the registered read of the per-alias character memories and the
// output register.
// Reset is synchronous and active high; it clears the alias list, the token
// state and all valid flags, while the character memories keep their contents.
// A stall on rsp backs up through the queue, and req_stall rises only when the
// queue is full.

module path_token_alias_matcher (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pta_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pta_pkg::rsp_type       rsp_data
);
   import pta_pkg::*;

   logic     push;
   item_type push_item;
   logic     pop;
   logic     head_valid;
   item_type head_item;
   logic     queue_full;

   pta_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   pta_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .full       (queue_full)
   );

   pta_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

>>> hw/rtl/pta_front.sv
`default_nettype none

module pta_front (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pta_pkg::req_type  req_data,
   input  wire logic              queue_full,
   output logic                   push,
   output pta_pkg::item_type      push_item
);
   import pta_pkg::*;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.byte_value = req_data.byte_value;
      push_item.last       = req_data.last;
      if (req_data.action) begin
         push_item.kind = is_separator(req_data.byte_value) ? KIND_PATH_SEP : KIND_PATH_CHAR;
      end else begin
         push_item.kind = (req_data.byte_value == CHAR_COMMA) ? KIND_ALIAS_COMMA
                                                              : KIND_ALIAS_CHAR;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pta_fifo.sv
`default_nettype none

module pta_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire pta_pkg::item_type  push_item,
   input  wire logic               pop,
   output logic                    head_valid,
   output pta_pkg::item_type       head_item,
   output logic                    full
);
   import pta_pkg::*;

   item_type        entries_ff [QUEUE_DEPTH];
   logic [QW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QW:0]     count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];
   assign full       = (count_ff == (QW+1)'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QW+1)'(1);
      end else if (!push && pop) begin
         count_in = count_ff - (QW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pta_back.sv
`default_nettype none

module pta_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire pta_pkg::item_type  head_item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output pta_pkg::rsp_type        rsp_data
);
   import pta_pkg::*;

   // Issue stage: alias bookkeeping, token position and alias store access.
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [LW-1:0]  wp_ff, wp_in;
   logic           open_ff, open_in;
   lens_type       lens_ff, lens_in;
   logic [TW-1:0]  tl_ff, tl_in;

   logic           wr_en;
   logic [IW-1:0]  wr_row;
   logic [AW-1:0]  wr_col;
   logic [AW-1:0]  rd_addr;
   exec_type       exec_in;

   // Execute stage: match tracking and result.
   logic           b_valid_ff;
   exec_type       b_data_ff;
   logic [7:0]     rd_data_ff [MAX_ALIASES];
   mask_type       sm_ff, sm_in;
   logic           found_ff, found_in;
   rsp_type        result;

   logic           out_free;
   logic           b_fire;
   logic           a_fire;

   rsp_type        rsp_data_ff;
   logic           rsp_valid_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign b_fire   = b_valid_ff && out_free;
   assign a_fire   = head_valid && (!b_valid_ff || out_free);
   assign pop      = a_fire;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rd_addr = (tl_ff < TW'(MAX_ALIAS_LEN)) ? tl_ff[AW-1:0] : '0;

   always_comb begin
      cnt_in  = cnt_ff;
      wp_in   = wp_ff;
      open_in = open_ff;
      lens_in = lens_ff;
      tl_in   = tl_ff;
      wr_en   = 1'b0;
      wr_row  = cnt_ff[IW-1:0];
      wr_col  = wp_ff[AW-1:0];

      exec_in.is_path    = 1'b0;
      exec_in.is_sep     = 1'b0;
      exec_in.last       = head_item.last;
      exec_in.byte_value = head_item.byte_value;
      exec_in.keep_mask  = '0;
      exec_in.close_mask = '0;
      exec_in.final_mask = '0;

      case (head_item.kind)
         KIND_ALIAS_CHAR, KIND_ALIAS_COMMA: begin
            if (!open_ff) begin
               cnt_in = '0;
               wp_in  = '0;
            end
            open_in = 1'b1;
            if (head_item.kind == KIND_ALIAS_COMMA) begin
               if (wp_in != '0 && cnt_in < CW'(MAX_ALIASES)) begin
                  lens_in[cnt_in[IW-1:0]] = wp_in;
                  cnt_in = cnt_in + CW'(1);
               end
               wp_in = '0;
            end else if (cnt_in < CW'(MAX_ALIASES) && wp_in < LW'(MAX_ALIAS_LEN)) begin
               wr_en  = 1'b1;
               wr_row = cnt_in[IW-1:0];
               wr_col = wp_in[AW-1:0];
               wp_in  = wp_in + LW'(1);
            end
            if (head_item.last) begin
               if (wp_in != '0 && cnt_in < CW'(MAX_ALIASES)) begin
                  lens_in[cnt_in[IW-1:0]] = wp_in;
                  cnt_in = cnt_in + CW'(1);
               end
               wp_in   = '0;
               open_in = 1'b0;
            end
         end
         KIND_PATH_SEP: begin
            exec_in.is_path    = 1'b1;
            exec_in.is_sep     = 1'b1;
            exec_in.close_mask = close_hits(tl_ff, cnt_ff, lens_ff);
            tl_in              = '0;
         end
         KIND_PATH_CHAR: begin
            exec_in.is_path   = 1'b1;
            exec_in.keep_mask = keep_allowed(tl_ff, cnt_ff, lens_ff);
            if (tl_ff <= TW'(MAX_ALIAS_LEN)) begin
               tl_in = tl_ff + TW'(1);
            end
         end
         default: begin
         end
      endcase

      if (exec_in.is_path && head_item.last) begin
         exec_in.final_mask = close_hits(tl_in, cnt_ff, lens_ff);
         tl_in              = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         wp_ff   <= '0;
         open_ff <= 1'b0;
         lens_ff <= '0;
         tl_ff   <= '0;
      end else if (a_fire) begin
         cnt_ff  <= cnt_in;
         wp_ff   <= wp_in;
         open_ff <= open_in;
         lens_ff <= lens_in;
         tl_ff   <= tl_in;
      end
   end

   for (genvar g = 0; g < MAX_ALIASES; g++) begin : g_lane
      logic [7:0] mem [MAX_ALIAS_LEN];

      always_ff @(posedge clock) begin
         if (a_fire && wr_en && wr_row == IW'(g)) begin
            mem[wr_col] <= head_item.byte_value;
         end
      end

      always_ff @(posedge clock) begin
         if (a_fire) begin
            rd_data_ff[g] <= mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!b_valid_ff || out_free) begin
         b_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_data_ff <= exec_in;
      end
   end

   always_comb begin
      mask_type eq;
      mask_type sm1;
      logic     found1;
      for (int i = 0; i < MAX_ALIASES; i++) begin
         eq[i] = (rd_data_ff[i] == b_data_ff.byte_value);
      end
      if (b_data_ff.is_sep) begin
         found1 = found_ff || ((sm_ff & b_data_ff.close_mask) != '0);
         sm1    = '1;
      end else begin
         found1 = found_ff;
         sm1    = sm_ff & b_data_ff.keep_mask & eq;
      end

      result.done_res = 1'b0;
      result.found    = 1'b0;
      sm_in           = sm_ff;
      found_in        = found_ff;
      if (b_data_ff.is_path) begin
         if (b_data_ff.last) begin
            result.done_res = 1'b1;
            result.found    = found1 || ((sm1 & b_data_ff.final_mask) != '0);
            sm_in           = '1;
            found_in        = 1'b0;
         end else begin
            sm_in    = sm1;
            found_in = found1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_ff    <= '1;
         found_ff <= 1'b0;
      end else if (b_fire) begin
         sm_ff    <= sm_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         rsp_data_ff <= result;
      end
   end

endmodule

`default_nettype wire
